>>> rtl/core/smmd_pkg.sv
// ----------------------------------------------------------------------------
// smmd_pkg
// Types and constants shared by the sweep min/max/mean decimator.
// ----------------------------------------------------------------------------
package smmd_pkg;

   localparam int CHAN_W    = 6;
   localparam int SAMP_W    = 16;
   localparam int PIX_W     = 12;
   localparam int CNT_W     = 11;
   localparam int SUM_W     = 26;
   localparam int PHASE_W   = 32;
   localparam int RATIO_W   = 27;
   localparam int SWIDTH_W  = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 27;

   // pixel position register is PIX_W wide, so the sweep limit is fixed with it
   localparam int MAX_PIXELS = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_RATIO  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TMODE  = 2'd2;

   localparam logic [RATIO_W-1:0]  RATIO_ONE   = 27'd65536;
   localparam logic [RATIO_W-1:0]  RATIO_MAX   = 27'd67108864;
   localparam logic [PHASE_W-1:0]  PHASE_ONE   = 32'd65536;
   localparam logic [SWIDTH_W-1:0] WIDTH_RESET = 13'd1024;

   localparam logic signed [SAMP_W-1:0] SAMP_TOP = 16'sh7fff;
   localparam logic signed [SAMP_W-1:0] SAMP_BOT = -16'sh8000;

   typedef struct packed {
      logic signed [SUM_W-1:0]  sum;
      logic signed [SAMP_W-1:0] low;
      logic signed [SAMP_W-1:0] high;
      logic [CNT_W-1:0]         samples;
      logic [PHASE_W-1:0]       phase;
      logic [PIX_W-1:0]         pos;
      logic                     waiting;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   localparam entry_type ENTRY_RESET = '{
      sum:     '0,
      low:     SAMP_TOP,
      high:    SAMP_BOT,
      samples: '0,
      phase:   '0,
      pos:     '0,
      waiting: 1'b0
   };

   typedef struct packed {
      logic [CHAN_W-1:0]        channel;
      logic signed [SAMP_W-1:0] sample;
      logic                     trigger;
      logic                     paused;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0]        out_channel;
      logic [PIX_W-1:0]         pixel_x;
      logic signed [SAMP_W-1:0] bin_mean;
      logic signed [SAMP_W-1:0] bin_min;
      logic signed [SAMP_W-1:0] bin_max;
      logic [CNT_W-1:0]         bin_count;
      logic                     sweep_end;
   } rsp_word_type;

endpackage

>>> rtl/core/smmd_req_if.sv
// ----------------------------------------------------------------------------
// smmd_req_if
// Sample input channel: valid/ready with one sample word.
// ----------------------------------------------------------------------------
interface smmd_req_if import smmd_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

>>> rtl/core/smmd_rsp_if.sv
// ----------------------------------------------------------------------------
// smmd_rsp_if
// Pixel result channel: valid/ready with one result word.
// ----------------------------------------------------------------------------
interface smmd_rsp_if import smmd_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

>>> rtl/core/smmd_ram.sv
// ----------------------------------------------------------------------------
// smmd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module smmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/smmd_div.sv
// ----------------------------------------------------------------------------
// smmd_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module smmd_div import smmd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    rem_sh;
   logic [CNT_W:0]    rem_sub;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = rem_sub[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/core/sweep_min_max_mean_decimator.sv
// ----------------------------------------------------------------------------
// sweep_min_max_mean_decimator
// Per-channel pixel binning of samples into mean, min, max and count.
// ----------------------------------------------------------------------------
//  channel   dir   handshake       word
//  req_chan  in    valid/ready     channel, sample, trigger, paused
//  rsp_chan  out   valid/ready     out_channel, pixel_x, bin_mean/min/max, count, end
//  csr_*     in    write enable    index, data
//
//  a sample is accepted, then the channel entry is read, modified and written;
//  a sample that closes an unpaused bin then runs the serial mean divider
//  and loads the result register once no earlier result is still pending on rsp.
//  reset is synchronous; per-channel entries read as cleared until first written.
//  a result waiting on rsp does not block the next sample until its own result is due.
// ----------------------------------------------------------------------------
module sweep_min_max_mean_decimator import smmd_pkg::*; #(
   parameter int CHANNELS   = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   smmd_req_if.sink             req_chan,
   smmd_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CALC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [RATIO_W-1:0]  ratio_ff;
   logic [SWIDTH_W-1:0] swidth_ff;
   logic                tmode_ff;

   req_word_type  word_ff;
   logic [AW-1:0] addr_ff;
   logic [CHANNELS-1:0] written_ff;

   rsp_word_type pend_ff, pend_in;
   logic         neg_ff, neg_in;
   rsp_word_type rsp_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   logic [ENTRY_W-1:0] rd_raw;
   entry_type cur, nxt;
   logic      ram_we;
   logic      accept;
   logic      in_range;

   logic [RATIO_W-1:0] ratio_eff;
   logic [16:0]        width_eff;
   logic               drop;
   logic               close;
   logic               last;
   logic [SUM_W-1:0]   sum_mag;
   logic               div_start, div_done;
   logic [SUM_W-1:0]   quo;
   logic [SAMP_W-1:0]  mean;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff  <= RATIO_ONE;
         swidth_ff <= WIDTH_RESET;
         tmode_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RATIO: ratio_ff  <= csr_wdata[RATIO_W-1:0];
            CSR_WIDTH: swidth_ff <= csr_wdata[SWIDTH_W-1:0];
            CSR_TMODE: tmode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ratio_eff = ratio_ff;
      if (ratio_ff < RATIO_ONE) ratio_eff = RATIO_ONE;
      if (ratio_ff > RATIO_MAX) ratio_eff = RATIO_MAX;
      width_eff = 17'(swidth_ff);
      if (swidth_ff == '0) width_eff = 17'd1;
      if (width_eff > 17'(MAX_PIXELS)) width_eff = 17'(MAX_PIXELS);
   end

   assign in_range       = 11'(req_chan.word.channel) < 11'(CHANNELS);
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   smmd_ram #(.WIDTH(ENTRY_W), .DEPTH(CHANNELS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr_ff),
      .wdata (nxt),
      .raddr (req_chan.word.channel[AW-1:0]),
      .rdata (rd_raw)
   );

   assign cur = written_ff[addr_ff] ? entry_type'(rd_raw) : ENTRY_RESET;

   // read-modify-write of the channel entry
   always_comb begin
      nxt   = cur;
      drop  = 1'b0;
      close = 1'b0;
      last  = 1'b0;
      if (cur.waiting) begin
         if (!tmode_ff) begin
            nxt.waiting = 1'b0;
         end else if (!word_ff.trigger) begin
            drop = 1'b1;
         end else begin
            nxt         = ENTRY_RESET;
            nxt.pos     = cur.pos;
         end
      end
      if (!drop) begin
         if (nxt.samples == '0) nxt.phase = nxt.phase + PHASE_W'(ratio_eff);
         nxt.phase   = nxt.phase - PHASE_ONE;
         nxt.sum     = nxt.sum + SUM_W'(word_ff.sample);
         if (word_ff.sample < nxt.low)  nxt.low  = word_ff.sample;
         if (word_ff.sample > nxt.high) nxt.high = word_ff.sample;
         nxt.samples = nxt.samples + 1'b1;
         close       = nxt.phase < PHASE_ONE;
      end
      pend_in = pend_ff;
      neg_in  = neg_ff;
      if (close) begin
         last                = (17'(nxt.pos) + 17'd1) >= width_eff;
         pend_in.out_channel = word_ff.channel;
         pend_in.pixel_x     = nxt.pos;
         pend_in.bin_mean    = '0;
         pend_in.bin_min     = nxt.low;
         pend_in.bin_max     = nxt.high;
         pend_in.bin_count   = nxt.samples;
         pend_in.sweep_end   = last;
         neg_in              = nxt.sum[SUM_W-1];
         sum_mag             = nxt.sum[SUM_W-1] ? SUM_W'(-nxt.sum) : SUM_W'(nxt.sum);
         nxt.sum     = '0;
         nxt.low     = SAMP_TOP;
         nxt.high    = SAMP_BOT;
         nxt.samples = '0;
         if (last) begin
            nxt.pos     = '0;
            nxt.waiting = tmode_ff;
         end else begin
            nxt.pos = nxt.pos + 1'b1;
         end
      end else begin
         sum_mag = '0;
      end
   end

   assign ram_we    = (state_ff == ST_CALC) && !drop;
   assign div_start = (state_ff == ST_CALC) && close && !word_ff.paused;

   smmd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (pend_in.bin_count),
      .done     (div_done),
      .quotient (quo)
   );

   assign mean = neg_ff ? SAMP_W'(-quo) : quo[SAMP_W-1:0];

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         ST_IDLE: if (accept && in_range) state_in = ST_CALC;
         ST_CALC: state_in = div_start ? ST_DIV : ST_IDLE;
         ST_DIV:  if (div_done) state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_valid_in) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         written_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_we) written_ff[addr_ff] <= 1'b1;
      end
      if (accept) begin
         word_ff <= req_chan.word;
         addr_ff <= req_chan.word.channel[AW-1:0];
      end
      if (state_ff == ST_CALC) begin
         pend_ff <= pend_in;
         neg_ff  <= neg_in;
      end
      if (state_ff == ST_EMIT && state_in == ST_IDLE) begin
         rsp_ff          <= pend_ff;
         rsp_ff.bin_mean <= mean;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.word  = rsp_ff;

   // checks
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised without emit");
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.bin_count != '0)
      else $error("empty bin delivered");
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.bin_min <= rsp_ff.bin_max)
      else $error("bin minimum above maximum");

endmodule
